FILE: design/bfha_pkg.sv
// Shared types and request codes for the best-fit heap allocator.
// No dependencies; used by the engine and the top level.
package bfha_pkg;

  localparam int unsigned AW = 20;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // One table entry: absolute start and length
  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] len;
  } ent_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [AW-1:0] addr;
    logic [AW-1:0] size;
    logic [AW-1:0] sp;
  } req_t;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic          ok;
  } rsp_t;

endpackage

FILE: design/bfha_ram.sv
// Table storage: one write port, one read port with registered read data.
// Uses bfha_pkg::ent_t as the word type.
module bfha_ram #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  bfha_pkg::ent_t           wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output bfha_pkg::ent_t           rdata_o
);

  bfha_pkg::ent_t mem [DEPTH];
  bfha_pkg::ent_t rdata_q;

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bfha_engine.sv
// Allocator sequencer: walks the free and live tables one entry at a time.
// Depends on bfha_pkg and bfha_ram.
module bfha_engine #(
  parameter int unsigned USER_BASE    = 196608,
  parameter int unsigned MEM_TOP      = 786432,
  parameter int unsigned FREE_ENTRIES = 16,
  parameter int unsigned LIVE_ENTRIES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bfha_pkg::req_t  req_i,
  output logic            idle_o,
  output logic            done_o,
  input  logic            ack_i,
  output bfha_pkg::rsp_t  rsp_o
);

  localparam int unsigned AW  = bfha_pkg::AW;
  localparam int unsigned FIW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int unsigned LIW = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;
  localparam int unsigned FCW = $clog2(FREE_ENTRIES + 1);
  localparam int unsigned LCW = $clog2(LIVE_ENTRIES + 1);
  localparam logic [AW:0]  UB_C    = (AW+1)'(USER_BASE);
  localparam logic [AW:0]  LIMIT_C = (MEM_TOP > USER_BASE) ?
                                     (AW+1)'(MEM_TOP - USER_BASE) : '0;
  localparam logic [FCW-1:0] FMAX_C = FCW'(FREE_ENTRIES);
  localparam logic [LCW-1:0] LMAX_C = LCW'(LIVE_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE, S_DONE,
    S_L_RD, S_L_EV,
    S_T_START, S_F_RD, S_F_EV, S_T_PICK, S_T_LIVE,
    S_DF_RD, S_DF_WR,
    S_DL_RD, S_DL_WR,
    S_R_START, S_R_RD, S_R_EV, S_R_APP
  } state_e;

  state_e state_q;

  logic [1:0]     op_q;
  logic [AW-1:0]  addr_q, size_q, sp_q;
  logic [AW-1:0]  bump_q;
  logic [FCW-1:0] fcnt_q, fi_q, k_q;
  logic [LCW-1:0] lcnt_q, li_q, oidx_q;
  logic [AW-1:0]  best_q, bs_q, bl_q, a_q, old_q, res_q, rn_q;
  logic [AW:0]    ra_q;
  logic           hb_q, have_old_q, ok_q;

  logic           fwe, lwe;
  logic [FIW-1:0] fwaddr, fraddr;
  logic [LIW-1:0] lwaddr, lraddr;
  bfha_pkg::ent_t fwdata, lwdata, frd, lrd;

  logic [FCW-1:0] fi_inc;
  logic [LCW-1:0] li_inc;
  logic [AW-1:0]  f_left;
  logic           is_free;
  logic [AW:0]    lim, bump_need, bump_abs, fs_end;
  logic [AW+1:0]  r_end;

  assign fi_inc    = fi_q + FCW'(1);
  assign li_inc    = li_q + LCW'(1);
  assign f_left    = frd.len - size_q;
  assign is_free   = (op_q == bfha_pkg::OP_FREE) || (size_q == '0);
  assign lim       = ({1'b0, sp_q} < LIMIT_C) ? {1'b0, sp_q} : LIMIT_C;
  assign bump_need = {1'b0, size_q} + {1'b0, bump_q};
  assign bump_abs  = {1'b0, bump_q} + UB_C;
  assign fs_end    = {1'b0, frd.start} + {1'b0, frd.len};
  assign r_end     = {1'b0, ra_q} + (AW+2)'(rn_q);

  bfha_ram #(.DEPTH(FREE_ENTRIES)) u_free (
    .clk_i, .we_i(fwe), .waddr_i(fwaddr), .wdata_i(fwdata),
    .raddr_i(fraddr), .rdata_o(frd)
  );

  bfha_ram #(.DEPTH(LIVE_ENTRIES)) u_live (
    .clk_i, .we_i(lwe), .waddr_i(lwaddr), .wdata_i(lwdata),
    .raddr_i(lraddr), .rdata_o(lrd)
  );

  // Drive table read and write ports from the current step
  always_comb begin
    fwe    = 1'b0;
    fwaddr = fi_q[FIW-1:0];
    fwdata = frd;
    fraddr = fi_q[FIW-1:0];
    lwe    = 1'b0;
    lwaddr = li_q[LIW-1:0];
    lwdata = lrd;
    lraddr = li_q[LIW-1:0];
    case (state_q)
      S_DF_RD: fraddr = fi_inc[FIW-1:0];
      S_DF_WR: fwe = 1'b1;
      S_DL_RD: lraddr = li_inc[LIW-1:0];
      S_DL_WR: lwe = 1'b1;
      S_T_PICK: begin
        fwe          = hb_q && (bl_q != size_q);
        fwaddr       = k_q[FIW-1:0];
        fwdata.start = bs_q + size_q;
        fwdata.len   = bl_q - size_q;
      end
      S_T_LIVE: begin
        lwe          = 1'b1;
        lwaddr       = lcnt_q[LIW-1:0];
        lwdata.start = a_q;
        lwdata.len   = size_q;
      end
      S_L_EV: begin
        lwe          = (lrd.start == addr_q) && !is_free && (size_q < lrd.len);
        lwdata.start = addr_q;
        lwdata.len   = size_q;
      end
      S_R_EV: begin
        fwe = (r_end == {1'b0, fs_end}) ? 1'b0 :
              ({2'b0, frd.start} == r_end) || (fs_end == ra_q);
        if ({2'b0, frd.start} == r_end) begin
          fwdata.start = frd.start - rn_q;
        end
        fwdata.len = frd.len + rn_q;
        if ({2'b0, frd.start} == r_end) begin
          fwe = 1'b1;
        end
      end
      S_R_APP: begin
        fwe          = fcnt_q < FMAX_C;
        fwaddr       = fcnt_q[FIW-1:0];
        fwdata.start = ra_q[AW-1:0];
        fwdata.len   = rn_q;
      end
      default: ;
    endcase
  end

  // Sequence one request through search, take, shift and release steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      bump_q     <= '0;
      fcnt_q     <= '0;
      lcnt_q     <= '0;
      hb_q       <= 1'b0;
      have_old_q <= 1'b0;
      ok_q       <= 1'b0;
      res_q      <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q       <= req_i.op;
            addr_q     <= req_i.addr;
            size_q     <= req_i.size;
            sp_q       <= req_i.sp;
            ok_q       <= 1'b0;
            res_q      <= '0;
            have_old_q <= 1'b0;
            li_q       <= '0;
            case (req_i.op)
              bfha_pkg::OP_ALLOC: state_q <= S_T_START;
              bfha_pkg::OP_FREE:  state_q <= S_L_RD;
              bfha_pkg::OP_RESIZE:
                state_q <= (req_i.addr != '0) ? S_L_RD : S_T_START;
              default: state_q <= S_DONE;
            endcase
          end
        end
        // Search the live table for the block address
        S_L_RD: begin
          if (li_q >= lcnt_q) begin
            state_q <= is_free ? S_DONE : S_T_START;
          end else begin
            state_q <= S_L_EV;
          end
        end
        S_L_EV: begin
          if (lrd.start == addr_q) begin
            if (is_free) begin
              ok_q    <= 1'b1;
              ra_q    <= {1'b0, addr_q};
              rn_q    <= lrd.len;
              state_q <= S_DL_RD;
            end else if (size_q < lrd.len) begin
              ok_q    <= 1'b1;
              res_q   <= addr_q;
              ra_q    <= {1'b0, addr_q} + {1'b0, size_q};
              rn_q    <= lrd.len - size_q;
              state_q <= S_R_START;
            end else begin
              have_old_q <= 1'b1;
              oidx_q     <= li_q;
              old_q      <= lrd.len;
              state_q    <= S_T_START;
            end
          end else begin
            li_q    <= li_inc;
            state_q <= S_L_RD;
          end
        end
        // Best-fit scan of the free table
        S_T_START: begin
          fi_q <= '0;
          hb_q <= 1'b0;
          if (lcnt_q >= LMAX_C) begin
            ok_q    <= 1'b0;
            res_q   <= '0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_F_RD;
          end
        end
        S_F_RD: begin
          state_q <= (fi_q >= fcnt_q) ? S_T_PICK : S_F_EV;
        end
        S_F_EV: begin
          if (frd.len >= size_q && (!hb_q || f_left < best_q)) begin
            best_q <= f_left;
            k_q    <= fi_q;
            bs_q   <= frd.start;
            bl_q   <= frd.len;
            hb_q   <= 1'b1;
          end
          if (frd.len >= size_q && f_left == '0) begin
            state_q <= S_T_PICK;
          end else begin
            fi_q    <= fi_inc;
            state_q <= S_F_RD;
          end
        end
        S_T_PICK: begin
          if (!hb_q) begin
            if (bump_need >= lim) begin
              ok_q    <= 1'b0;
              res_q   <= '0;
              state_q <= S_DONE;
            end else begin
              a_q     <= bump_abs[AW-1:0];
              bump_q  <= bump_need[AW-1:0];
              state_q <= S_T_LIVE;
            end
          end else begin
            a_q <= bs_q;
            if (bl_q == size_q) begin
              fi_q    <= k_q;
              state_q <= S_DF_RD;
            end else begin
              state_q <= S_T_LIVE;
            end
          end
        end
        // Close the gap of a fully used free entry
        S_DF_RD: begin
          if (fi_inc >= fcnt_q) begin
            fcnt_q  <= fcnt_q - FCW'(1);
            state_q <= S_T_LIVE;
          end else begin
            state_q <= S_DF_WR;
          end
        end
        S_DF_WR: begin
          fi_q    <= fi_inc;
          state_q <= S_DF_RD;
        end
        S_T_LIVE: begin
          lcnt_q <= lcnt_q + LCW'(1);
          res_q  <= a_q;
          ok_q   <= 1'b1;
          if (have_old_q) begin
            li_q    <= oidx_q;
            ra_q    <= {1'b0, addr_q};
            rn_q    <= old_q;
            state_q <= S_DL_RD;
          end else begin
            state_q <= S_DONE;
          end
        end
        // Close the gap of a dropped live entry
        S_DL_RD: begin
          if (li_inc >= lcnt_q) begin
            lcnt_q  <= lcnt_q - LCW'(1);
            state_q <= S_R_START;
          end else begin
            state_q <= S_DL_WR;
          end
        end
        S_DL_WR: begin
          li_q    <= li_inc;
          state_q <= S_DL_RD;
        end
        // Return a range to the bump pointer or the free table
        S_R_START: begin
          fi_q <= '0;
          if (ra_q < UB_C || rn_q == '0) begin
            state_q <= S_DONE;
          end else if ({1'b0, bump_abs} == r_end) begin
            bump_q  <= bump_q - rn_q;
            state_q <= S_DONE;
          end else begin
            state_q <= S_R_RD;
          end
        end
        S_R_RD: begin
          state_q <= (fi_q >= fcnt_q) ? S_R_APP : S_R_EV;
        end
        S_R_EV: begin
          if ({2'b0, frd.start} == r_end || fs_end == ra_q ||
              ({1'b0, frd.start} <= ra_q && {1'b0, fs_end} >= r_end)) begin
            state_q <= S_DONE;
          end else begin
            fi_q    <= fi_inc;
            state_q <= S_R_RD;
          end
        end
        S_R_APP: begin
          if (fcnt_q < FMAX_C) begin
            fcnt_q <= fcnt_q + FCW'(1);
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign idle_o     = (state_q == S_IDLE);
  assign done_o     = (state_q == S_DONE);
  assign rsp_o.addr = res_q;
  assign rsp_o.ok   = ok_q;

`ifndef ASSERT_OFF
  a_lcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcnt_q <= LMAX_C) else $error("live count beyond table depth");
  a_fcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= FMAX_C) else $error("free count beyond table depth");
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !start_i) |=>
      ($stable(bump_q) && $stable(lcnt_q) && $stable(fcnt_q)))
    else $error("allocator state moved while idle");
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_q) |-> (res_q == '0))
    else $error("failed request carries an address");
`endif

endmodule

FILE: design/best_fit_heap_allocator_core.sv
// Best-fit heap allocator: a request (allocate, free, resize) is taken when
// the engine is idle and answered with one result. The live-table search, the
// best-fit scan of the free table, the entry shifts after a removal and the
// neighbor search of a release each step through one table entry at a time
// over the single read port of that table. The live search and the live shift
// together cover the live table once, as do the free scan and its shift. The
// engine takes no new request until it is through with the last one, and a
// result that meets a stalled output register holds the engine until it moves.
// A finished result waits in the output register while the next request is
// taken.
module best_fit_heap_allocator_core #(
  parameter int unsigned USER_BASE    = 196608,
  parameter int unsigned MEM_TOP      = 786432,
  parameter int unsigned FREE_ENTRIES = 16,
  parameter int unsigned LIVE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [19:0] addr_i,
  input  logic [19:0] size_i,
  input  logic [19:0] stack_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [19:0] result_addr_o,
  output logic        success_o
);

  logic           idle, done, ack, start;
  bfha_pkg::req_t req;
  bfha_pkg::rsp_t rsp, out_q;
  logic           out_valid_q;

  assign req.op   = op_i;
  assign req.addr = addr_i;
  assign req.size = size_i;
  assign req.sp   = stack_offset_i;

  assign start      = in_valid_i && idle;
  assign in_stall_o = !idle;
  assign ack        = !out_valid_q || !out_stall_i;

  bfha_engine #(
    .USER_BASE(USER_BASE), .MEM_TOP(MEM_TOP),
    .FREE_ENTRIES(FREE_ENTRIES), .LIVE_ENTRIES(LIVE_ENTRIES)
  ) u_engine (
    .clk_i, .rst_ni, .start_i(start), .req_i(req),
    .idle_o(idle), .done_o(done), .ack_i(ack), .rsp_o(rsp)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ack) begin
      out_valid_q <= done;
      if (done) begin
        out_q <= rsp;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_addr_o = out_q.addr;
  assign success_o     = out_q.ok;

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_addr_o)))
    else $error("stalled result changed");
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while busy");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !success_o) |-> (result_addr_o == '0))
    else $error("failed result carries an address");
`endif

endmodule
